/* hdl/nfp_pkg.sv */
// ----------------------------------------------------------------------------
// nfp_pkg
// Shared types, constants and arithmetic helpers for the Newton fractal core.
// ----------------------------------------------------------------------------
package nfp_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int ITER_LIMIT = 512;
  localparam int ITER_W     = $clog2(ITER_LIMIT + 1);
  localparam int COLOR_BASE = 512;
  localparam int CAP_W      = 10;
  localparam int MIN_W      = (ITER_W > CAP_W) ? ITER_W : CAP_W;

  typedef logic signed [63:0] fx_t;

  localparam fx_t SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fx_t SAT_MIN = -SAT_MAX;
  localparam fx_t FX_TWO  = fx_t'(64'sd2 <<< FRAC_BITS);
  localparam fx_t FX_ZERO = '0;

  typedef struct packed {
    logic [30:0]      col_step;
    logic [30:0]      row_step;
    logic [28:0]      tolerance;
    logic [CAP_W-1:0] color_cap;
  } cfg_t;

  typedef struct packed {
    fx_t x;
    fx_t y;
  } point_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_SQA,
    OP_SQB
  } op_t;

  typedef enum logic [3:0] {
    R_X, R_Y, R_X2, R_Y2, R_T0, R_T1, R_FR, R_FI, R_DR, R_DI, R_DEN, R_TWO, R_ZERO
  } opd_t;

  typedef struct packed {
    op_t  op;
    opd_t a;
    opd_t b;
    opd_t dst;
  } uop_t;

  localparam int UOP_COUNT = 40;
  localparam int PC_W      = $clog2(UOP_COUNT);

  typedef enum logic [1:0] {
    CFG_COL_STEP  = 2'd0,
    CFG_ROW_STEP  = 2'd1,
    CFG_TOLERANCE = 2'd2,
    CFG_COLOR_CAP = 2'd3
  } cfg_idx_t;

  function automatic logic [62:0] mag(fx_t a);
    fx_t n;
    n = -a;
    return a[63] ? n[62:0] : a[62:0];
  endfunction

  function automatic fx_t sat_add(fx_t a, fx_t b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SAT_MAX)) return SAT_MAX;
    else if (s < 65'(SAT_MIN)) return SAT_MIN;
    else return fx_t'(s[63:0]);
  endfunction

  function automatic fx_t sat_sub(fx_t a, fx_t b);
    return sat_add(a, -b);
  endfunction

  // one Newton iteration: f, f', numerators, two divisions, step test
  function automatic uop_t uop_at(logic [PC_W-1:0] pc);
    uop_t u;
    u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    unique case (pc)
      6'd0:  u = '{OP_MUL, R_X,   R_X,    R_T0};
      6'd1:  u = '{OP_MUL, R_Y,   R_Y,    R_T1};
      6'd2:  u = '{OP_SUB, R_T0,  R_T1,   R_X2};
      6'd3:  u = '{OP_MUL, R_X,   R_Y,    R_T0};
      6'd4:  u = '{OP_ADD, R_T0,  R_T0,   R_Y2};
      6'd5:  u = '{OP_MUL, R_X2,  R_X,    R_T0};
      6'd6:  u = '{OP_MUL, R_Y2,  R_Y,    R_T1};
      6'd7:  u = '{OP_SUB, R_T0,  R_T1,   R_T0};
      6'd8:  u = '{OP_ADD, R_X,   R_X,    R_T1};
      6'd9:  u = '{OP_SUB, R_T0,  R_T1,   R_T0};
      6'd10: u = '{OP_ADD, R_T0,  R_TWO,  R_FR};
      6'd11: u = '{OP_MUL, R_X2,  R_Y,    R_T0};
      6'd12: u = '{OP_MUL, R_Y2,  R_X,    R_T1};
      6'd13: u = '{OP_ADD, R_T0,  R_T1,   R_T0};
      6'd14: u = '{OP_ADD, R_Y,   R_Y,    R_T1};
      6'd15: u = '{OP_SUB, R_T0,  R_T1,   R_FI};
      6'd16: u = '{OP_ADD, R_X2,  R_X2,   R_T0};
      6'd17: u = '{OP_ADD, R_T0,  R_X2,   R_T0};
      6'd18: u = '{OP_SUB, R_T0,  R_TWO,  R_DR};
      6'd19: u = '{OP_ADD, R_Y2,  R_Y2,   R_T0};
      6'd20: u = '{OP_ADD, R_T0,  R_Y2,   R_DI};
      6'd21: u = '{OP_MUL, R_DR,  R_DR,   R_T0};
      6'd22: u = '{OP_MUL, R_DI,  R_DI,   R_T1};
      6'd23: u = '{OP_ADD, R_T0,  R_T1,   R_DEN};
      6'd24: u = '{OP_MUL, R_FR,  R_DR,   R_T0};
      6'd25: u = '{OP_MUL, R_FI,  R_DI,   R_T1};
      6'd26: u = '{OP_ADD, R_T0,  R_T1,   R_X2};
      6'd27: u = '{OP_MUL, R_FI,  R_DR,   R_T0};
      6'd28: u = '{OP_MUL, R_FR,  R_DI,   R_T1};
      6'd29: u = '{OP_SUB, R_T0,  R_T1,   R_Y2};
      6'd30: u = '{OP_DIV, R_X2,  R_DEN,  R_T0};
      6'd31: u = '{OP_SUB, R_X,   R_T0,   R_T1};
      6'd32: u = '{OP_SUB, R_X,   R_T1,   R_FR};
      6'd33: u = '{OP_ADD, R_T1,  R_ZERO, R_X};
      6'd34: u = '{OP_DIV, R_Y2,  R_DEN,  R_T0};
      6'd35: u = '{OP_SUB, R_Y,   R_T0,   R_T1};
      6'd36: u = '{OP_SUB, R_Y,   R_T1,   R_FI};
      6'd37: u = '{OP_ADD, R_T1,  R_ZERO, R_Y};
      6'd38: u = '{OP_SQA, R_FR,  R_FR,   R_T0};
      6'd39: u = '{OP_SQB, R_FI,  R_FI,   R_T0};
      default: u = '{OP_ADD, R_ZERO, R_ZERO, R_T0};
    endcase
    return u;
  endfunction

endpackage

/* hdl/nfp_if.sv */
// ----------------------------------------------------------------------------
// nfp_if
// Valid/ready channels for pixel coordinates and pixel colors.
// ----------------------------------------------------------------------------
interface nfp_pixel_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_row;
  logic [11:0] pixel_col;
  modport source(output valid, pixel_row, pixel_col, input ready);
  modport sink(input valid, pixel_row, pixel_col, output ready);
endinterface

interface nfp_color_if;
  logic       valid;
  logic       ready;
  logic [8:0] red;
  logic [8:0] green;
  logic [8:0] blue;
  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

/* hdl/nfp_front.sv */
// ----------------------------------------------------------------------------
// nfp_front
// Accepts pixel transactions and maps row/column to the Newton start point.
// ----------------------------------------------------------------------------
module nfp_front import nfp_pkg::*; (
  nfp_pixel_if.sink pixel,
  input  cfg_t      cfg,
  input  logic      full,
  output logic      push,
  output point_t    push_data
);

  logic [42:0] col_off;
  logic [42:0] row_off;

  assign col_off = 43'(pixel.pixel_col) * 43'(cfg.col_step);
  assign row_off = 43'(pixel.pixel_row) * 43'(cfg.row_step);

  assign pixel.ready  = !full;
  assign push         = pixel.valid && !full;
  assign push_data.x  = fx_t'(col_off) - FX_TWO;
  assign push_data.y  = FX_TWO - fx_t'(row_off);

endmodule

/* hdl/nfp_queue.sv */
// ----------------------------------------------------------------------------
// nfp_queue
// Two-entry queue of start points between the front and the iteration engine.
// ----------------------------------------------------------------------------
module nfp_queue import nfp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  point_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output point_t head
);

  point_t     entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hdl/nfp_mul.sv */
// ----------------------------------------------------------------------------
// nfp_mul
// Saturating fixed-point multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module nfp_mul import nfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  fx_t          a,
  input  fx_t          b,
  output logic         done,
  output fx_t          prod,
  output logic [127:0] raw
);

  localparam logic [127:0] RND = 128'(1) << (FRAC_BITS - 1);

  logic [62:0]  ma;
  logic [62:0]  mb;
  logic         neg;
  logic         busy;
  logic [2:0]   cnt;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] rs;
  logic [62:0]  q;

  always_comb begin
    opa = cnt[1] ? {1'b0, ma[62:32]} : ma[31:0];
    opb = (cnt == 3'd1 || cnt == 3'd3) ? {1'b0, mb[62:32]} : mb[31:0];
    pp  = 64'(opa) * 64'(opb);
    unique case (cnt)
      3'd0:       pp_sh = {64'b0, pp};
      3'd1, 3'd2: pp_sh = {32'b0, pp, 32'b0};
      default:    pp_sh = {pp, 64'b0};
    endcase
    rs = raw + RND;
    q  = (|rs[127:63+FRAC_BITS]) ? SAT_MAX[62:0] : rs[62+FRAC_BITS:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma   <= mag(a);
        mb   <= mag(b);
        neg  <= a[63] != b[63];
        raw  <= '0;
        cnt  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          raw <= raw + pp_sh;
          cnt <= cnt + 3'd1;
        end else begin
          prod <= neg ? -fx_t'({1'b0, q}) : fx_t'({1'b0, q});
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/nfp_div.sv */
// ----------------------------------------------------------------------------
// nfp_div
// Saturating fixed-point divider, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nfp_div import nfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  fx_t  n,
  input  fx_t  d,
  output logic done,
  output fx_t  quot
);

  localparam int DVW = 63 + FRAC_BITS;
  localparam int CW  = $clog2(DVW);

  logic [DVW-1:0] dvd;
  logic [DVW-1:0] quo;
  logic [62:0]    rem;
  logic [62:0]    ud;
  logic           neg;
  logic           busy;
  logic           fin;
  logic [CW-1:0]  cnt;
  logic [63:0]    rs;
  logic           ge;
  logic [63:0]    diff;
  logic [62:0]    q;

  always_comb begin
    rs   = {rem, dvd[DVW-1]};
    ge   = rs >= {1'b0, ud};
    diff = rs - {1'b0, ud};
    q    = (|quo[DVW-1:63]) ? SAT_MAX[62:0] : quo[62:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (d == FX_ZERO) begin
          quot <= n[63] ? SAT_MIN : SAT_MAX;
          done <= 1'b1;
        end else begin
          dvd  <= {mag(n), {FRAC_BITS{1'b0}}};
          ud   <= mag(d);
          neg  <= n[63] != d[63];
          rem  <= '0;
          quo  <= '0;
          cnt  <= CW'(DVW - 1);
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem  <= ge ? diff[62:0] : rs[62:0];
        quo  <= {quo[DVW-2:0], ge};
        dvd  <= dvd << 1;
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        quot <= neg ? -fx_t'({1'b0, q}) : fx_t'({1'b0, q});
        done <= 1'b1;
        fin  <= 1'b0;
      end
    end
  end

endmodule

/* hdl/nfp_back.sv */
// ----------------------------------------------------------------------------
// nfp_back
// Newton iteration sequencer, step test and pixel color output register.
// ----------------------------------------------------------------------------
module nfp_back import nfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_valid,
  input  point_t       q_head,
  output logic         q_pop,
  nfp_color_if.source  color
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_WAIT  = 5'b00100,
    S_CHECK = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t            state;
  logic [PC_W-1:0]   pc;
  logic [ITER_W-1:0] n;
  fx_t               x, y, x2, y2, t0, t1, fr, fi, dr, di, den;
  logic [127:0]      sqa;
  logic [127:0]      sqsum;
  logic [57:0]       tol_sq;
  logic              hit;
  logic              out_valid;
  logic [8:0]        red_q, green_q, blue_q;

  uop_t         u;
  fx_t          opa, opb, alu, wr_val;
  logic         wr_en;
  logic         is_mul, is_div, unit_done;
  logic         mul_done, div_done;
  fx_t          mul_prod, div_quot;
  logic [127:0] mul_raw;
  logic [MIN_W-1:0] m;
  logic [MIN_W:0]   c_full;
  logic [8:0]       c;

  function automatic fx_t pick(opd_t s, fx_t vx, fx_t vy, fx_t vx2, fx_t vy2, fx_t vt0,
                               fx_t vt1, fx_t vfr, fx_t vfi, fx_t vdr, fx_t vdi,
                               fx_t vden);
    fx_t v;
    unique case (s)
      R_X:     v = vx;
      R_Y:     v = vy;
      R_X2:    v = vx2;
      R_Y2:    v = vy2;
      R_T0:    v = vt0;
      R_T1:    v = vt1;
      R_FR:    v = vfr;
      R_FI:    v = vfi;
      R_DR:    v = vdr;
      R_DI:    v = vdi;
      R_DEN:   v = vden;
      R_TWO:   v = FX_TWO;
      default: v = FX_ZERO;
    endcase
    return v;
  endfunction

  always_comb begin
    u         = uop_at(pc);
    opa       = pick(u.a, x, y, x2, y2, t0, t1, fr, fi, dr, di, den);
    opb       = pick(u.b, x, y, x2, y2, t0, t1, fr, fi, dr, di, den);
    alu       = (u.op == OP_SUB) ? sat_sub(opa, opb) : sat_add(opa, opb);
    is_mul    = (u.op == OP_MUL) || (u.op == OP_SQA) || (u.op == OP_SQB);
    is_div    = (u.op == OP_DIV);
    unit_done = (is_mul && mul_done) || (is_div && div_done);
    wr_en     = 1'b0;
    wr_val    = alu;
    if (state == S_EXEC && !is_mul && !is_div) begin
      wr_en = 1'b1;
    end else if (state == S_WAIT && u.op == OP_MUL && mul_done) begin
      wr_en  = 1'b1;
      wr_val = mul_prod;
    end else if (state == S_WAIT && is_div && div_done) begin
      wr_en  = 1'b1;
      wr_val = div_quot;
    end
    m      = (MIN_W'(n) < MIN_W'(cfg.color_cap)) ? MIN_W'(n) : MIN_W'(cfg.color_cap);
    c_full = (m >= MIN_W'(COLOR_BASE)) ? '0 : (MIN_W+1)'(COLOR_BASE) - (MIN_W+1)'(m);
    c      = (c_full > (MIN_W+1)'(511)) ? 9'h1FF : c_full[8:0];
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  nfp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EXEC && is_mul),
    .a     (opa),
    .b     (opb),
    .done  (mul_done),
    .prod  (mul_prod),
    .raw   (mul_raw)
  );

  nfp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_EXEC && is_div),
    .n     (opa),
    .d     (opb),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (u.dst)
        R_X:     x   <= wr_val;
        R_Y:     y   <= wr_val;
        R_X2:    x2  <= wr_val;
        R_Y2:    y2  <= wr_val;
        R_T0:    t0  <= wr_val;
        R_T1:    t1  <= wr_val;
        R_FR:    fr  <= wr_val;
        R_FI:    fi  <= wr_val;
        R_DR:    dr  <= wr_val;
        R_DI:    di  <= wr_val;
        R_DEN:   den <= wr_val;
        default: ;
      endcase
    end else if (q_pop) begin
      x <= q_head.x;
      y <= q_head.y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      n         <= '0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_OUT && (!out_valid || color.ready)) out_valid <= 1'b1;
      else if (color.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            tol_sq <= 58'(cfg.tolerance) * 58'(cfg.tolerance);
            n      <= ITER_W'(1);
            pc     <= '0;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (is_mul || is_div) state <= S_WAIT;
          else pc <= pc + PC_W'(1);
        end
        S_WAIT: begin
          if (unit_done) begin
            if (u.op == OP_SQA) begin
              sqa   <= mul_raw;
              pc    <= pc + PC_W'(1);
              state <= S_EXEC;
            end else if (u.op == OP_SQB) begin
              sqsum <= sqa + mul_raw;
              state <= S_CHECK;
            end else begin
              pc    <= pc + PC_W'(1);
              state <= S_EXEC;
            end
          end
        end
        S_CHECK: begin
          hit <= sqsum < 128'(tol_sq);
          if (sqsum < 128'(tol_sq) || n == ITER_W'(ITER_LIMIT)) begin
            state <= S_OUT;
          end else begin
            n     <= n + ITER_W'(1);
            pc    <= '0;
            state <= S_EXEC;
          end
        end
        S_OUT: begin
          if (!out_valid || color.ready) begin
            if (!hit) begin
              red_q <= '0; green_q <= '0; blue_q <= '0;
            end else if (mag(y) < 63'(cfg.tolerance)) begin
              red_q <= c; green_q <= c; blue_q <= '0;
            end else if (!y[63]) begin
              red_q <= '0; green_q <= c; blue_q <= c;
            end else begin
              red_q <= c; green_q <= '0; blue_q <= c;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign color.valid = out_valid;
  assign color.red   = red_q;
  assign color.green = green_q;
  assign color.blue  = blue_q;

endmodule

/* hdl/newton_fractal_pixel_color_core.sv */
// ----------------------------------------------------------------------------
// newton_fractal_pixel_color_core
// Newton fractal for z^3 - 2z + 2: one color transaction per pixel transaction.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  pixel    in   valid/ready   pixel_row[11:0], pixel_col[11:0]
//  color    out  valid/ready   red[8:0], green[8:0], blue[8:0]
//  cfg      in   cfg_write     cfg_index[2:0], cfg_data[30:0]
//
//  A pixel takes 1..512 Newton iterations; each iteration runs 15 products on the
//  shared multiplier, two quotients on the bit-serial divider (a zero divisor
//  skips the bit-serial loop), 23 add/sub steps and the step test.
//  Reset is synchronous and loads the default register values; no clearing pass.
//  A two-entry queue lets pixels be taken while a color waits on color.ready.
// ----------------------------------------------------------------------------
module newton_fractal_pixel_color_core import nfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  nfp_pixel_if.sink   pixel,
  nfp_color_if.source color,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  cfg_t   cfg;
  logic   push, full, pop, q_valid;
  point_t push_data, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_step  <= 31'd2097152;
      cfg.row_step  <= 31'd2097152;
      cfg.tolerance <= 29'd26844;
      cfg.color_cap <= CAP_W'(30);
    end else if (cfg_write && !cfg_index[2]) begin
      unique case (cfg_idx_t'(cfg_index[1:0]))
        CFG_COL_STEP:  cfg.col_step  <= cfg_data;
        CFG_ROW_STEP:  cfg.row_step  <= cfg_data;
        CFG_TOLERANCE: cfg.tolerance <= cfg_data[28:0];
        CFG_COLOR_CAP: cfg.color_cap <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  nfp_front u_front (
    .pixel     (pixel),
    .cfg       (cfg),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  nfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head)
  );

  nfp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_head  (head),
    .q_pop   (pop),
    .color   (color)
  );

endmodule
